// ===== hw/rtl/jsch_pkg.sv =====
// ----------------------------------------------------------------------------
// jsch_pkg
// Shared types, constants and the CRC byte update for the sampled JPEG hash.
// ----------------------------------------------------------------------------
package jsch_pkg;

	localparam int unsigned REM_BITS = 16;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [7:0]  MARK_FF  = 8'hFF;
	localparam logic [7:0]  MARK_SOI = 8'hD8;
	localparam logic [7:0]  STUFF_00 = 8'h00;

	typedef enum logic [3:0] {
		PH_SOI0,
		PH_SOI1,
		PH_SEEK,
		PH_FILL,
		PH_LENHI,
		PH_LENLO,
		PH_SKIP,
		PH_FOUND,
		PH_FALLBACK,
		PH_FAIL
	} phase_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/jsch_div.sv =====
// ----------------------------------------------------------------------------
// jsch_div
// Constant divider: length by the sample target, reciprocal multiply with
// registered product, quotient and remainder.
// ----------------------------------------------------------------------------
module jsch_div
	import jsch_pkg::*;
#(
	parameter int unsigned LENGTH_BITS   = 31,
	parameter int unsigned SAMPLE_TARGET = 10000
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [LENGTH_BITS-1:0] dividend,
	output logic                   busy,
	output logic [LENGTH_BITS-1:0] quotient,
	output logic [REM_BITS-1:0]    remainder
);

	// (x * RECIP) >> SHIFT is the exact quotient for every x below 2**LENGTH_BITS
	localparam int unsigned TGT_BITS = $clog2(SAMPLE_TARGET);
	localparam int unsigned SHIFT    = LENGTH_BITS + TGT_BITS;
	localparam int unsigned RW       = LENGTH_BITS + 2;
	localparam int unsigned PRW      = LENGTH_BITS + RW;
	localparam longint unsigned RECIP_W =
		((64'd1 << SHIFT) + 64'(SAMPLE_TARGET) - 64'd1) / 64'(SAMPLE_TARGET);
	localparam logic [RW-1:0]       RECIP = RW'(RECIP_W);
	localparam logic [REM_BITS-1:0] TGT   = REM_BITS'(SAMPLE_TARGET);

	logic [2:0]             stg_q;
	logic [LENGTH_BITS-1:0] num_q;
	logic [PRW-1:0]         prod_q;
	logic [LENGTH_BITS-1:0] quo_q;
	logic [REM_BITS-1:0]    rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q  <= '0;
			num_q  <= '0;
			prod_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			stg_q <= {stg_q[1:0], start};
			if (start) num_q <= dividend;
			if (stg_q[0]) prod_q <= PRW'(num_q) * PRW'(RECIP);
			if (stg_q[1]) quo_q <= LENGTH_BITS'(prod_q >> SHIFT);
			// remainder is below 2**REM_BITS, so the low bits are enough
			if (stg_q[2]) rem_q <= REM_BITS'(num_q) - REM_BITS'(quo_q) * TGT;
		end
	end

	assign busy      = |stg_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/jpeg_sampled_crc_hash.sv =====
// ----------------------------------------------------------------------------
// jpeg_sampled_crc_hash
// Sampled CRC-32 and byte-sum hash of a JPEG stream after its header.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle, back to back, and returns one result beat
// (crc_value, byte_sum) in the cycle after the last byte of each stream is
// accepted. Only the last byte of a stream waits for the previous result beat
// to leave. A write of stream_length restarts the stream and divides the
// length by SAMPLE_TARGET with a reciprocal multiply; data_ready stays low
// after the write while the quotient settles and is loaded. The quotient and
// remainder of the bytes left are then tracked by a countdown, so the sample
// step is known on the byte where hashing starts.
module jpeg_sampled_crc_hash
	import jsch_pkg::*;
#(
	parameter int unsigned SAMPLE_TARGET = 10000,
	parameter int unsigned LENGTH_BITS   = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [LENGTH_BITS-1:0] stream_length,
	input  logic                   data_valid,
	output logic                   data_ready,
	input  logic [7:0]             data_byte,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [31:0]            crc_value,
	output logic [31:0]            byte_sum
);

	localparam int unsigned L = LENGTH_BITS;
	localparam logic [REM_BITS-1:0] TMAX = REM_BITS'(SAMPLE_TARGET - 1);

	logic            div_busy;
	logic [L-1:0]    div_q;
	logic [REM_BITS-1:0] div_r;

	jsch_div #(.LENGTH_BITS(L), .SAMPLE_TARGET(SAMPLE_TARGET)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_write),
		.dividend  (stream_length),
		.busy      (div_busy),
		.quotient  (div_q),
		.remainder (div_r)
	);

	logic [L-1:0]        len_q, pos_q, step_q, next_q, snext_q, run_q;
	logic [REM_BITS-1:0] run_r_q;
	logic                run_ld_q;
	phase_t              phase_q, phase_n, phase_n_f;
	logic [15:0]         seg_q, seg_n;
	logic [7:0]          prev_q;
	logic [31:0]         mcrc_q, msum_q, scrc_q, ssum_q;
	logic                res_valid_q;
	logic [31:0]         res_crc_q, res_sum_q;

	function automatic logic [L-1:0] adv(input logic [L-1:0] p, input logic [L-1:0] s);
		logic [L:0] n;
		n = {1'b0, p} + {1'b0, s};
		return n[L] ? {L{1'b1}} : n[L-1:0];
	endfunction

	logic         accept;
	logic [L-1:0] sstep, pos_n, pos_m1, start_s, span, qsel, step_n, next_n;
	logic         found, from_prev, late;
	logic [15:0]  seglen;
	logic [31:0]  scrc_n, ssum_n, mcrc_n, msum_n;
	logic [L-1:0] snext_n, next_f;
	logic         last;

	// only the last byte of a stream waits for a pending result beat
	assign data_ready = !div_busy && !run_ld_q && (!last || !res_valid_q || result_ready);
	assign accept     = data_valid && data_ready;
	assign sstep      = (div_q == '0) ? L'(1) : div_q;
	assign pos_n      = pos_q + L'(1);
	assign pos_m1     = pos_q - L'(1);
	assign seglen     = {prev_q, data_byte};

	// shadow pair hashes from offset 0
	always_comb begin
		scrc_n  = scrc_q;
		ssum_n  = ssum_q;
		snext_n = snext_q;
		if (pos_q == snext_q) begin
			scrc_n  = crc_byte(scrc_q, data_byte);
			ssum_n  = ssum_q + {24'd0, data_byte};
			snext_n = adv(snext_q, sstep);
		end
	end

	// header walk
	always_comb begin
		phase_n   = phase_q;
		seg_n     = seg_q;
		found     = 1'b0;
		from_prev = 1'b0;
		unique case (phase_q)
			PH_SOI0: phase_n = (data_byte == MARK_FF) ? PH_SOI1 : PH_FAIL;
			PH_SOI1: phase_n = (data_byte == MARK_SOI) ? PH_SEEK : PH_FAIL;
			PH_SEEK: begin
				if (data_byte == MARK_FF) phase_n = PH_FILL;
				else found = 1'b1;
			end
			PH_FILL: begin
				if (data_byte == STUFF_00) found = 1'b1;
				else if (data_byte != MARK_FF) phase_n = PH_LENHI;
			end
			PH_LENHI: phase_n = PH_LENLO;
			PH_LENLO: begin
				priority if (seglen == 16'd0) begin
					found     = 1'b1;
					from_prev = 1'b1;
				end else if (seglen == 16'd1) begin
					found = 1'b1;
				end else if (seglen == 16'd2) begin
					phase_n = PH_SEEK;
				end else begin
					seg_n   = seglen - 16'd2;
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				seg_n = seg_q - 16'd1;
				if (seg_n == 16'd0) phase_n = PH_SEEK;
			end
			default: ;
		endcase
	end

	// start handling and main pair
	assign start_s = from_prev ? pos_m1 : pos_q;
	assign span    = len_q - start_s;
	assign late    = (start_s >= len_q) || (span < L'(4));
	assign qsel    = (from_prev && run_r_q == TMAX) ? (run_q + L'(1)) : run_q;

	always_comb begin
		phase_t ph;
		ph     = phase_n;
		step_n = step_q;
		next_f = next_q;
		mcrc_n = mcrc_q;
		msum_n = msum_q;
		if (found) begin
			if (late) begin
				ph = PH_FALLBACK;
			end else begin
				ph     = PH_FOUND;
				step_n = (qsel == '0) ? L'(1) : qsel;
				next_f = start_s;
				mcrc_n = CRC_INIT;
				msum_n = '0;
				if (from_prev) begin
					// start sits on the previous byte
					mcrc_n = crc_byte(CRC_INIT, prev_q);
					msum_n = {24'd0, prev_q};
					next_f = adv(start_s, step_n);
				end
			end
		end
		next_n = next_f;
		if (ph == PH_FOUND && pos_q == next_f) begin
			mcrc_n = crc_byte(mcrc_n, data_byte);
			msum_n = msum_n + {24'd0, data_byte};
			next_n = adv(next_f, step_n);
		end
		phase_n_f = ph;
	end

	assign last = (pos_n == len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pos_q       <= '0;
			phase_q     <= PH_SOI0;
			seg_q       <= '0;
			prev_q      <= '0;
			step_q      <= L'(1);
			next_q      <= '0;
			mcrc_q      <= CRC_INIT;
			msum_q      <= '0;
			snext_q     <= '0;
			scrc_q      <= CRC_INIT;
			ssum_q      <= '0;
			run_q       <= '0;
			run_r_q     <= '0;
			run_ld_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (accept && last && !cfg_write) || (res_valid_q && !result_ready);
			if (cfg_write || (accept && last)) begin
				if (cfg_write) begin
					len_q    <= stream_length;
					run_ld_q <= 1'b1;
				end else begin
					run_q   <= div_q;
					run_r_q <= div_r;
				end
				pos_q   <= '0;
				phase_q <= PH_SOI0;
				seg_q   <= '0;
				prev_q  <= '0;
				step_q  <= L'(1);
				next_q  <= '0;
				mcrc_q  <= CRC_INIT;
				msum_q  <= '0;
				snext_q <= '0;
				scrc_q  <= CRC_INIT;
				ssum_q  <= '0;
			end else if (run_ld_q) begin
				// load the countdown once the divider settles
				if (!div_busy) begin
					run_q    <= div_q;
					run_r_q  <= div_r;
					run_ld_q <= 1'b0;
				end
			end else if (accept) begin
				pos_q   <= pos_n;
				phase_q <= phase_n_f;
				seg_q   <= seg_n;
				prev_q  <= data_byte;
				step_q  <= step_n;
				next_q  <= next_n;
				mcrc_q  <= mcrc_n;
				msum_q  <= msum_n;
				snext_q <= snext_n;
				scrc_q  <= scrc_n;
				ssum_q  <= ssum_n;
				if (run_r_q == '0) begin
					run_q   <= run_q - L'(1);
					run_r_q <= TMAX;
				end else begin
					run_r_q <= run_r_q - REM_BITS'(1);
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && last && !cfg_write) begin
			if (len_q < L'(3) || phase_n_f == PH_FAIL) begin
				res_crc_q <= '0;
				res_sum_q <= '0;
			end else if (phase_n_f == PH_FOUND) begin
				res_crc_q <= mcrc_n;
				res_sum_q <= msum_n;
			end else begin
				res_crc_q <= scrc_n;
				res_sum_q <= ssum_n;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign crc_value    = res_crc_q;
	assign byte_sum     = res_sum_q;

endmodule

// ===== tb/sv/jpeg_sampled_crc_hash_chk.sv =====
// ----------------------------------------------------------------------------
// jpeg_sampled_crc_hash_chk
// Predicts and checks the sampled CRC-32 / byte-sum hash at the ports.
// ----------------------------------------------------------------------------
// Follows every accepted length write and stream byte with its own parser
// and hash state, queues the digest due after the last byte of each stream
// and compares each result beat against the oldest queued digest.
module jpeg_sampled_crc_hash_chk
	import jsch_pkg::*;
#(
	parameter int unsigned SAMPLE_TARGET = 10000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [30:0] stream_length,
	input  logic        data_valid,
	input  logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [31:0] crc_value,
	input  logic [31:0] byte_sum,
	output int          digests_due,
	output int          mismatches
);

	localparam logic [30:0] POS_MAX = 31'h7FFFFFFF;

	typedef struct packed {
		logic [31:0] crc;
		logic [31:0] sum;
	} digest_t;

	digest_t     digest_q[$];
	logic [30:0] len_r, pos_r, start_r, step_r, next_r, sh_step, sh_next;
	logic [15:0] seg_left;
	logic [7:0]  prev0, prev1;
	logic [31:0] crc_m, sum_m, crc_s, sum_s;
	phase_t      ph;

	function automatic logic [31:0] crc_fold(logic [31:0] c, logic [7:0] b);
		c = c ^ {24'd0, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [30:0] step_of(logic [30:0] span);
		logic [30:0] q;
		q = 31'(span / SAMPLE_TARGET);
		return (q == 0) ? 31'd1 : q;
	endfunction

	// saturate so a pointer past the end never matches a live byte
	function automatic logic [30:0] bump(logic [30:0] p, logic [30:0] st);
		longint unsigned n;
		n = longint'(p) + longint'(st);
		return (n > POS_MAX) ? POS_MAX : n[30:0];
	endfunction

	task automatic restart_stream();
		pos_r    = '0;
		ph       = PH_SOI0;
		seg_left = '0;
		prev0    = '0;
		prev1    = '0;
		start_r  = '0;
		step_r   = 31'd1;
		next_r   = '0;
		crc_m    = CRC_INIT;
		sum_m    = '0;
		sh_step  = step_of(len_r);
		sh_next  = '0;
		crc_s    = CRC_INIT;
		sum_s    = '0;
	endtask

	task automatic take_start(logic [30:0] s, logic [30:0] pos);
		if (s >= len_r || len_r - s < 4) begin
			ph = PH_FALLBACK;
		end else begin
			ph      = PH_FOUND;
			start_r = s;
			step_r  = step_of(len_r - s);
			next_r  = s;
			crc_m   = CRC_INIT;
			sum_m   = '0;
			// start sits on the byte already seen
			if (s != pos) begin
				crc_m  = crc_fold(crc_m, prev0);
				sum_m  = sum_m + prev0;
				next_r = bump(next_r, step_r);
			end
		end
	endtask

	task automatic predict_byte(logic [7:0] b);
		logic [30:0] pos;
		logic [15:0] seglen;
		digest_t     d;
		pos = pos_r;
		if (pos == sh_next) begin
			crc_s   = crc_fold(crc_s, b);
			sum_s   = sum_s + b;
			sh_next = bump(sh_next, sh_step);
		end
		case (ph)
			PH_SOI0: ph = (b == MARK_FF) ? PH_SOI1 : PH_FAIL;
			PH_SOI1: ph = (b == MARK_SOI) ? PH_SEEK : PH_FAIL;
			PH_SEEK: begin
				if (b == MARK_FF) ph = PH_FILL;
				else take_start(pos, pos);
			end
			PH_FILL: begin
				if (b == STUFF_00) take_start(pos, pos);
				else if (b != MARK_FF) ph = PH_LENHI;
			end
			PH_LENHI: ph = PH_LENLO;
			PH_LENLO: begin
				seglen = {prev0, b};
				if (seglen == 0) take_start(pos - 31'd1, pos);
				else if (seglen == 1) take_start(pos, pos);
				else if (seglen == 2) ph = PH_SEEK;
				else begin
					seg_left = seglen - 16'd2;
					ph       = PH_SKIP;
				end
			end
			PH_SKIP: begin
				seg_left = seg_left - 16'd1;
				if (seg_left == 0) ph = PH_SEEK;
			end
			default: ;
		endcase
		if (ph == PH_FOUND && pos == next_r) begin
			crc_m  = crc_fold(crc_m, b);
			sum_m  = sum_m + b;
			next_r = bump(next_r, step_r);
		end
		prev1 = prev0;
		prev0 = b;
		pos_r = pos + 31'd1;
		if (pos_r == len_r) begin
			if (len_r < 3 || ph == PH_FAIL) d = '0;
			else if (ph == PH_FOUND) d = '{crc_m, sum_m};
			else d = '{crc_s, sum_s};
			digest_q.push_back(d);
			restart_stream();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_t d;
		if (!arst_n) begin
			len_r = '0;
			restart_stream();
			digest_q.delete();
			mismatches = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (digest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat crc=%h sum=%h", crc_value, byte_sum);
				end else begin
					d = digest_q.pop_front();
					if (crc_value !== d.crc || byte_sum !== d.sum) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: exp crc=%h sum=%h got crc=%h sum=%h",
								d.crc, d.sum, crc_value, byte_sum);
					end
				end
			end
			if (cfg_write) begin
				len_r = stream_length;
				restart_stream();
			end
			if (data_valid && data_ready) predict_byte(data_byte);
		end
		digests_due = digest_q.size();
	end

endmodule

// ===== tb/sv/jpeg_sampled_crc_hash_tb.sv =====
// ----------------------------------------------------------------------------
// jpeg_sampled_crc_hash_tb
// Stream stimulus and verdict for the sampled JPEG hash.
// ----------------------------------------------------------------------------
// Writes a range of stream lengths and feeds JPEG-like streams (fill runs,
// markers, short and zero-length segments, stuffed zeros, broken SOI) with
// random gaps and result back-pressure; the checker does the comparing.
module jpeg_sampled_crc_hash_tb
	import jsch_pkg::*;
();

	localparam int WATCHDOG = 4000;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [30:0] stream_length;
	logic        data_valid;
	logic        data_ready;
	logic [7:0]  data_byte;
	logic        result_valid;
	logic        result_ready;
	logic [31:0] crc_value;
	logic [31:0] byte_sum;
	int          digests_due;
	int          mismatches;

	logic [7:0]  strm[$];
	bit          quiet;
	bit          long_hold;
	int          hold_cnt;
	int          gap_cnt;
	int          idle_cycles;
	int          bytes_sent;

	jpeg_sampled_crc_hash u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.stream_length(stream_length),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.crc_value    (crc_value),
		.byte_sum     (byte_sum)
	);

	jpeg_sampled_crc_hash_chk u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.stream_length(stream_length),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.crc_value    (crc_value),
		.byte_sum     (byte_sum),
		.digests_due  (digests_due),
		.mismatches   (mismatches)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		result_ready = 1'b0;
		hold_cnt     = 0;
		gap_cnt      = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold_cnt  = 300;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_ready <= 1'b0;
			end else if (gap_cnt > 0) begin
				gap_cnt--;
				result_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				gap_cnt = $urandom_range(0, 2);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((data_valid && data_ready) || (result_valid && result_ready) || cfg_write)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		do @(negedge clk); while (digests_due != 0);
		@(posedge clk);
	endtask

	// only between streams: let the block settle, then write
	task automatic set_length(logic [30:0] len);
		wait_drained();
		repeat (40) @(posedge clk);
		cfg_write     <= 1'b1;
		stream_length <= len;
		@(posedge clk);
		cfg_write     <= 1'b0;
	endtask

	task automatic send_byte(logic [7:0] b);
		data_valid <= 1'b1;
		data_byte  <= b;
		do @(posedge clk); while (!data_ready);
		bytes_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_stream(int unsigned len);
		while (strm.size() < len) strm.push_back(8'($urandom_range(0, 255)));
		for (int unsigned i = 0; i < len; i++) send_byte(strm[i]);
		data_valid <= 1'b0;
		strm.delete();
	endtask

	task automatic pad_random(int unsigned len);
		while (strm.size() < len) strm.push_back(8'($urandom_range(0, 255)));
	endtask

	// mostly well-formed header walks with random content, some noise
	task automatic build_stream(int unsigned len);
		int unsigned sel, seglen;
		strm.delete();
		if ($urandom_range(0, 9) == 0) begin
			strm.push_back($urandom_range(0, 1) ? MARK_FF : 8'($urandom_range(0, 255)));
			strm.push_back($urandom_range(0, 1) ? MARK_SOI : 8'($urandom_range(0, 255)));
		end else begin
			strm.push_back(MARK_FF);
			strm.push_back(MARK_SOI);
			while (strm.size() < len) begin
				sel = $urandom_range(0, 9);
				if (sel < 2) begin
					strm.push_back(8'($urandom_range(0, 254)));
					break;
				end else if (sel == 2) begin
					repeat ($urandom_range(1, 3)) strm.push_back(MARK_FF);
					strm.push_back(STUFF_00);
					break;
				end
				repeat ($urandom_range(1, 2)) strm.push_back(MARK_FF);
				strm.push_back(8'($urandom_range(1, 254)));
				sel = $urandom_range(0, 19);
				if (sel < 2) begin
					strm.push_back(8'h00);
					strm.push_back(sel == 0 ? 8'h00 : 8'h01);
					break;
				end
				seglen = (sel == 2) ? $urandom_range(3, 65535) : $urandom_range(2, 9);
				strm.push_back(seglen[15:8]);
				strm.push_back(seglen[7:0]);
				repeat (seglen - 2) begin
					if (strm.size() >= len) break;
					strm.push_back(8'($urandom_range(0, 255)));
				end
			end
		end
		pad_random(len);
	endtask

	task automatic directed_stream(logic [7:0] head[]);
		foreach (head[i]) strm.push_back(head[i]);
		send_stream(12);
	endtask

	initial begin
		int unsigned len;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		stream_length = '0;
		data_valid    = 1'b0;
		data_byte     = '0;
		quiet         = 1'b0;
		long_hold     = 1'b0;
		idle_cycles   = 0;
		bytes_sent    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_length(31'd12);
		directed_stream('{8'hFF, 8'hD8, 8'h00});
		directed_stream('{8'hFF, 8'hD8, 8'h7A});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'h00});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h00});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h01});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h02, 8'h33});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'hAA, 8'hBB, 8'h7F});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'hFF, 8'h00});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hDB, 8'h00, 8'h03, 8'h00,
			8'hFF, 8'hFF, 8'h12});
		directed_stream('{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF});
		directed_stream('{8'h00, 8'hD8});
		directed_stream('{8'hFF, 8'h00});
		set_length(31'd3);
		strm = '{8'hFF, 8'hD8, 8'h00};
		send_stream(3);
		set_length(31'd1);
		send_stream(1);
		set_length(31'd2);
		strm = '{8'hFF, 8'hD8};
		send_stream(2);

		// length zero and the largest length: partial streams, then restart
		set_length(31'd0);
		strm = '{8'hFF, 8'hD8, 8'h00};
		send_stream(40);
		set_length(31'h7FFFFFFF);
		strm = '{8'hFF, 8'hD8, 8'h00};
		send_stream(200);

		// receiver holds off while short streams pile up
		set_length(31'd3);
		long_hold = 1'b1;
		repeat (30) begin
			build_stream(3);
			send_stream(3);
		end

		bytes_sent = 0;
		while (bytes_sent < 800) begin
			case ($urandom_range(0, 9))
				0:       len = $urandom_range(1, 4);
				1:       len = $urandom_range(65, 300);
				default: len = $urandom_range(5, 40);
			endcase
			set_length(31'(len));
			repeat ($urandom_range(2, 6)) begin
				build_stream(len);
				send_stream(len);
				if ($urandom_range(0, 4) == 0) wait_drained();
			end
		end

		// last stretch with no idling
		quiet = 1'b1;
		set_length(31'd24);
		repeat (10) begin
			build_stream(24);
			send_stream(24);
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && digests_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/jsch_pkg.sv
hw/rtl/jsch_div.sv
hw/rtl/jpeg_sampled_crc_hash.sv
tb/sv/jpeg_sampled_crc_hash_chk.sv
tb/sv/jpeg_sampled_crc_hash_tb.sv
